### hw/rtl/bcom_pkg.sv
// Shared types, codes and compare helpers for the barcode classifier.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package bcom_pkg;

  localparam int MAX_BARCODE_LEN = 16;  // bases per barcode and per read prefix
  localparam int ENTRY_W         = 6;   // entry_index and barcode_index width
  localparam int IDX_W           = 10;  // widest table index carried in a job
  localparam int CNT_W           = 32;  // hit and undetermined counters
  localparam int CODE_W          = 2 * MAX_BARCODE_LEN;
  localparam int READ_W          = 3 * MAX_BARCODE_LEN;
  localparam int LEN_W           = 5;
  localparam int COUNT_W         = 7;
  localparam int CFG_DATA_W      = 7;
  localparam int Q_DEPTH         = 2;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_RD_CNT   = 2'd2,
    OP_RD_UND   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_LEN      = 2'd0,
    CFG_MISMATCH = 2'd1,
    CFG_PAIRED   = 2'd2,
    CFG_COUNT    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic               mm;
    logic               paired;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  typedef enum logic [2:0] {
    JOB_LOAD   = 3'd0,
    JOB_HIT    = 3'd1,
    JOB_MISS   = 3'd2,
    JOB_RD_CNT = 3'd3,
    JOB_RD_UND = 3'd4
  } job_kind_t;

  // One unit of counter work handed from the front to the back.
  typedef struct packed {
    job_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             inc2;
  } job_t;

  // Lanes compared for a given length setting; length clamps to 1..MAX_BARCODE_LEN.
  function automatic logic [MAX_BARCODE_LEN-1:0] bcom_mask(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0]           n;
    logic [MAX_BARCODE_LEN-1:0] m;
    n = len;
    if (len == '0) n = LEN_W'(1);
    if (len > LEN_W'(MAX_BARCODE_LEN)) n = LEN_W'(MAX_BARCODE_LEN);
    for (int i = 0; i < MAX_BARCODE_LEN; i++) begin
      m[i] = (LEN_W'(i) < n);
    end
    return m;
  endfunction

  // Match one stored barcode against one read prefix: no N in the active
  // lanes, and zero differing lanes (or at most one when mm is set).
  function automatic logic bcom_match(input logic [CODE_W-1:0]          code,
                                      input logic [READ_W-1:0]          rd,
                                      input logic [MAX_BARCODE_LEN-1:0] mask,
                                      input logic                       mm);
    logic [MAX_BARCODE_LEN-1:0] diff;
    logic                       bad;
    bad = 1'b0;
    for (int i = 0; i < MAX_BARCODE_LEN; i++) begin
      bad     = bad | (mask[i] & rd[3*i+2]);
      diff[i] = mask[i] & (rd[3*i +: 2] != code[2*i +: 2]);
    end
    return !bad && ((diff == '0) ||
                    (mm && ((diff & (diff - MAX_BARCODE_LEN'(1))) == '0)));
  endfunction

endpackage

### hw/rtl/barcode_classifier_one_mismatch_top.sv
// Top level of the barcode classifier: config registers, front end, job
// queue and counter back end. Depends on bcom_pkg and the bcom_* modules.
`timescale 1ns / 1ps
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  command  | start, busy            | in_op, in_entry_index, in_barcode_bases,
//           |                        | in_read1_bases, in_read2_bases
//  result   | out_valid (1 cycle)    | out_matched, out_barcode_index, out_count_value
//  config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
//  A command beat is taken when start is high and busy is low; one result beat
//  follows for every command, in order. After reset the back end zeroes the hit
//  counters, one per cycle, with busy held high. Load and counter reads are
//  taken back to back while the two-entry job queue has room; an in-range
//  counter read also passes the back end's wait state. A classify holds busy
//  until its job is pushed, longer while the queue is full: the front end scans
//  the barcode table through its one read port, one entry per cycle; with no
//  entry in use it is taken like a load. The hit update in the back end reads
//  the counter, then writes it back from its wait state. Results cannot be
//  stalled; config writes are always ready.

module barcode_classifier_one_mismatch_top import bcom_pkg::*; #(
  parameter int MAX_BARCODES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [ENTRY_W-1:0]    in_entry_index,
  input  logic [CODE_W-1:0]     in_barcode_bases,
  input  logic [READ_W-1:0]     in_read1_bases,
  input  logic [READ_W-1:0]     in_read2_bases,
  output logic                  out_valid,
  output logic                  out_matched,
  output logic [ENTRY_W-1:0]    out_barcode_index,
  output logic [CNT_W-1:0]      out_count_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEN_W-1:0]   len_r;
  logic               mm_r;
  logic               paired_r;
  logic [COUNT_W-1:0] count_r;
  cfg_t               cfg;

  logic accept;
  logic f_busy, b_clearing;
  logic q_push, q_full, q_pop, q_empty;
  job_t push_job, pop_job;

  assign cfg_ready = 1'b1;
  assign cfg       = '{len: len_r, mm: mm_r, paired: paired_r, count: count_r};
  assign busy      = f_busy || q_full || b_clearing;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= LEN_W'(8);
      mm_r     <= 1'b0;
      paired_r <= 1'b0;
      count_r  <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LEN:      len_r    <= cfg_data[LEN_W-1:0];
        CFG_MISMATCH: mm_r     <= cfg_data[0];
        CFG_PAIRED:   paired_r <= cfg_data[0];
        CFG_COUNT:    count_r  <= cfg_data[COUNT_W-1:0];
        default:      count_r  <= count_r;
      endcase
    end
  end

  bcom_front #(
    .MAX_BARCODES(MAX_BARCODES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .accept        (accept),
    .op            (in_op),
    .entry_index   (in_entry_index),
    .barcode_bases (in_barcode_bases),
    .read1_bases   (in_read1_bases),
    .read2_bases   (in_read2_bases),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job),
    .busy          (f_busy)
  );

  bcom_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  bcom_back #(
    .MAX_BARCODES(MAX_BARCODES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_job             (pop_job),
    .q_pop             (q_pop),
    .clearing          (b_clearing),
    .out_valid         (out_valid),
    .out_matched       (out_matched),
    .out_barcode_index (out_barcode_index),
    .out_count_value   (out_count_value)
  );

endmodule

### hw/rtl/bcom_front.sv
// Front end: takes commands, owns the barcode table and scans it for reads.
// Pushes one counter job per command into the queue. Depends on bcom_pkg.
`timescale 1ns / 1ps

module bcom_front import bcom_pkg::*; #(
  parameter int MAX_BARCODES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               accept,
  input  logic [1:0]         op,
  input  logic [ENTRY_W-1:0] entry_index,
  input  logic [CODE_W-1:0]  barcode_bases,
  input  logic [READ_W-1:0]  read1_bases,
  input  logic [READ_W-1:0]  read2_bases,
  input  logic               q_full,
  output logic               q_push,
  output job_t               q_job,
  output logic               busy
);

  localparam int AW = (MAX_BARCODES > 1) ? $clog2(MAX_BARCODES) : 1;
  localparam int CW = $clog2(MAX_BARCODES + 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SCAN = 3'b010,
    F_DONE = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [CODE_W-1:0] tbl_mem [MAX_BARCODES];
  logic [CODE_W-1:0] rd_data_r;
  logic [READ_W-1:0] read1_r, read2_r;

  logic [AW-1:0] iss_idx_r, iss_idx_nxt;
  logic          iss_on_r, iss_on_nxt;
  logic          iss_last_r, iss_last_nxt;
  logic [AW-1:0] cmp_idx_r;
  logic          cmp_on_r, cmp_last_r;

  logic          hit1_r, hit1_nxt, hit2_r, hit2_nxt;
  logic [AW-1:0] win1_r, win1_nxt, win2_r, win2_nxt;

  logic                       in_range;
  logic [CW-1:0]              n_used;
  logic [MAX_BARCODE_LEN-1:0] mask;
  logic                       hit1_now, hit2_now;
  logic                       tbl_we;
  logic [AW-1:0]              tbl_waddr;
  logic                       latch_reads;

  assign in_range  = 32'(entry_index) < 32'(MAX_BARCODES);
  assign tbl_waddr = AW'(entry_index);
  assign n_used    = (32'(cfg.count) > 32'(MAX_BARCODES)) ? CW'(MAX_BARCODES)
                                                           : CW'(cfg.count);
  assign mask      = bcom_mask(cfg.len);
  assign hit1_now  = bcom_match(rd_data_r, read1_r, mask, cfg.mm);
  assign hit2_now  = bcom_match(rd_data_r, read2_r, mask, cfg.mm);
  assign busy      = (state_r != F_IDLE);

  always_comb begin
    state_nxt    = state_r;
    iss_idx_nxt  = iss_idx_r;
    iss_on_nxt   = iss_on_r;
    iss_last_nxt = iss_last_r;
    hit1_nxt     = hit1_r;
    hit2_nxt     = hit2_r;
    win1_nxt     = win1_r;
    win2_nxt     = win2_r;
    tbl_we       = 1'b0;
    latch_reads  = 1'b0;
    q_push       = 1'b0;
    q_job        = '{kind: JOB_MISS, idx: '0, in_range: 1'b0, inc2: 1'b0};
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          case (op_t'(op))
            OP_LOAD: begin
              tbl_we         = in_range;
              q_push         = 1'b1;
              q_job.kind     = JOB_LOAD;
              q_job.idx      = IDX_W'(entry_index);
              q_job.in_range = in_range;
            end
            OP_CLASSIFY: begin
              if (n_used == '0) begin
                // no entry in use: a plain miss
                q_push     = 1'b1;
                q_job.kind = JOB_MISS;
                q_job.inc2 = cfg.paired;
              end else begin
                latch_reads  = 1'b1;
                iss_on_nxt   = 1'b1;
                iss_idx_nxt  = AW'(n_used - CW'(1));
                iss_last_nxt = (n_used == CW'(1));
                hit1_nxt     = 1'b0;
                hit2_nxt     = 1'b0;
                state_nxt    = F_SCAN;
              end
            end
            OP_RD_CNT: begin
              q_push         = 1'b1;
              q_job.kind     = JOB_RD_CNT;
              q_job.idx      = IDX_W'(entry_index);
              q_job.in_range = in_range;
            end
            OP_RD_UND: begin
              q_push     = 1'b1;
              q_job.kind = JOB_RD_UND;
            end
            default: begin
              q_push = 1'b0;
            end
          endcase
        end
      end
      F_SCAN: begin
        // walk entries from the highest in use down to zero
        if (iss_on_r) begin
          if (iss_last_r) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_idx_nxt  = iss_idx_r - AW'(1);
            iss_last_nxt = (iss_idx_r == AW'(1));
          end
        end
        // first hit on the way down is the highest index
        if (cmp_on_r) begin
          if (!hit1_r && hit1_now) begin
            hit1_nxt = 1'b1;
            win1_nxt = cmp_idx_r;
          end
          if (!hit2_r && hit2_now) begin
            hit2_nxt = 1'b1;
            win2_nxt = cmp_idx_r;
          end
          if (cmp_last_r) state_nxt = F_DONE;
        end
      end
      F_DONE: begin
        if (!q_full) begin
          q_push     = 1'b1;
          q_job.inc2 = cfg.paired;
          if (cfg.paired && hit2_r) begin
            q_job.kind = JOB_HIT;
            q_job.idx  = IDX_W'(win2_r);
          end else if (hit1_r) begin
            q_job.kind = JOB_HIT;
            q_job.idx  = IDX_W'(win1_r);
          end
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      iss_on_r   <= 1'b0;
      iss_last_r <= 1'b0;
      cmp_on_r   <= 1'b0;
      cmp_last_r <= 1'b0;
      hit1_r     <= 1'b0;
      hit2_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      iss_on_r   <= iss_on_nxt;
      iss_last_r <= iss_last_nxt;
      cmp_on_r   <= iss_on_r;
      cmp_last_r <= iss_last_r;
      hit1_r     <= hit1_nxt;
      hit2_r     <= hit2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_idx_r <= iss_idx_nxt;
    cmp_idx_r <= iss_idx_r;
    win1_r    <= win1_nxt;
    win2_r    <= win2_nxt;
    if (latch_reads) begin
      read1_r <= read1_bases;
      read2_r <= read2_bases;
    end
  end

  // barcode table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= barcode_bases;
    rd_data_r <= tbl_mem[iss_idx_r];
  end

endmodule

### hw/rtl/bcom_queue.sv
// Short job queue between the front end and the counter back end.
// Two entries of job_t; depends on bcom_pkg.
`timescale 1ns / 1ps

module bcom_queue import bcom_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  job_t          slot_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign full    = (fill_r == (PW+1)'(Q_DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    case ({do_push, do_pop})
      2'b10:   fill_nxt = fill_r + (PW+1)'(1);
      2'b01:   fill_nxt = fill_r - (PW+1)'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

### hw/rtl/bcom_back.sv
// Back end: owns the hit counters and the undetermined counter, runs the
// queued jobs and drives the registered result beat. Depends on bcom_pkg.
`timescale 1ns / 1ps

module bcom_back import bcom_pkg::*; #(
  parameter int MAX_BARCODES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  job_t               q_job,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  output logic               out_matched,
  output logic [ENTRY_W-1:0] out_barcode_index,
  output logic [CNT_W-1:0]   out_count_value
);

  localparam int AW = (MAX_BARCODES > 1) ? $clog2(MAX_BARCODES) : 1;

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_WAIT  = 3'b100
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_mem [MAX_BARCODES];
  logic [CNT_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0] und_r, und_nxt;
  job_t             job_r, job_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CNT_W-1:0] mem_wdata;

  logic               emit;
  logic               emit_matched;
  logic [ENTRY_W-1:0] emit_idx;
  logic [CNT_W-1:0]   emit_cnt;

  logic               out_valid_r;
  logic               out_matched_r;
  logic [ENTRY_W-1:0] out_barcode_index_r;
  logic [CNT_W-1:0]   out_count_value_r;

  assign rd_addr  = AW'(q_job.idx);
  assign clearing = (state_r == B_CLEAR);

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    und_nxt      = und_r;
    job_nxt      = job_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = AW'(q_job.idx);
    mem_wdata    = '0;
    emit         = 1'b0;
    emit_matched = 1'b0;
    emit_idx     = '0;
    emit_cnt     = '0;
    case (state_r)
      B_CLEAR: begin
        // zero every counter once after reset
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(MAX_BARCODES - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_job.kind)
            JOB_LOAD: begin
              mem_we = q_job.in_range;
              emit   = 1'b1;
            end
            JOB_MISS: begin
              und_nxt = und_r + CNT_W'(q_job.inc2 ? 2 : 1);
              emit    = 1'b1;
            end
            JOB_RD_UND: begin
              emit     = 1'b1;
              emit_cnt = und_r;
            end
            JOB_HIT: begin
              job_nxt   = q_job;
              state_nxt = B_WAIT;
            end
            JOB_RD_CNT: begin
              if (q_job.in_range) begin
                job_nxt   = q_job;
                state_nxt = B_WAIT;
              end else begin
                emit = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      B_WAIT: begin
        // counter word is in rd_data_r now
        emit      = 1'b1;
        state_nxt = B_IDLE;
        if (job_r.kind == JOB_HIT) begin
          mem_we       = 1'b1;
          mem_waddr    = AW'(job_r.idx);
          mem_wdata    = rd_data_r + CNT_W'(job_r.inc2 ? 2 : 1);
          emit_matched = 1'b1;
          emit_idx     = job_r.idx[ENTRY_W-1:0];
        end else begin
          emit_cnt = rd_data_r;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_idx_r   <= '0;
      und_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      und_r       <= und_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (emit) begin
      out_matched_r       <= emit_matched;
      out_barcode_index_r <= emit_idx;
      out_count_value_r   <= emit_cnt;
    end
  end

  // counter memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) cnt_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= cnt_mem[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_matched       = out_matched_r;
  assign out_barcode_index = out_barcode_index_r;
  assign out_count_value   = out_count_value_r;

endmodule
